// ===== hdl/b64lwe_pkg.sv =====
// Shared types, constants and the character table of the base64 line-wrapping encoder.
`default_nettype none

package b64lwe_pkg;

	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned SEXTET_W   = 6;
	localparam int unsigned GROUP_W    = 8;
	localparam int unsigned JOB_CHARS  = 4;
	localparam int unsigned JOB_IDX_W  = $clog2(JOB_CHARS);
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CHAR_W-1:0] PAD_CHAR     = 8'h3D;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

	localparam logic [GROUP_W-1:0] LINE_GROUPS_RESET = 8'd20;

	localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_GROUPS = 1'b1;

	localparam logic MODE_DATA  = 1'b0;
	localparam logic MODE_CLOSE = 1'b1;

	// One unit of output work: up to four characters, first in element 0.
	typedef struct packed {
		logic [JOB_CHARS-1:0][CHAR_W-1:0] chars;
		logic [JOB_IDX_W-1:0]             last_idx;
	} job_t;

	// Queue status seen by the back end.
	typedef struct packed {
		logic full;
		logic avail;
	} jobq_stat_t;

	// RFC 4648 alphabet.
	function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
		logic [CHAR_W-1:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/b64lwe_front.sv =====
// Front end: accepts bytes, tracks group and line state, builds character jobs.
`default_nettype none

module b64lwe_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic                          mode,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          wrap_enable,
	input  wire logic [b64lwe_pkg::GROUP_W-1:0] line_groups,
	output b64lwe_pkg::job_t                   job,
	output logic                               job_push
);
	import b64lwe_pkg::*;

	logic [15:0]        held_q;
	logic [1:0]         phase_q;
	logic [GROUP_W-1:0] groups_q;

	logic [GROUP_W-1:0] limit;
	logic               line_full;
	logic [7:0]         b0;
	logic [7:0]         b1;

	assign limit     = (line_groups == '0) ? GROUP_W'(1) : line_groups;
	assign line_full = (groups_q >= limit);
	assign b0        = (phase_q == 2'd2) ? held_q[15:8] : held_q[7:0];
	assign b1        = held_q[7:0];

	always_comb begin
		job      = '0;
		job_push = 1'b0;
		if (mode == MODE_DATA) begin
			case (phase_q)
				2'd0: begin
					job.chars[0] = NEWLINE_CHAR;
					job_push     = accept && line_full && wrap_enable;
				end
				2'd2: begin
					job.chars[0] = sextet_char(b0[7:2]);
					job.chars[1] = sextet_char({b0[1:0], b1[7:4]});
					job.chars[2] = sextet_char({b1[3:0], data_byte[7:6]});
					job.chars[3] = sextet_char(data_byte[5:0]);
					job.last_idx = JOB_IDX_W'(3);
					job_push     = accept;
				end
				default: begin
				end
			endcase
		end else begin
			case (phase_q)
				2'd1: begin
					job.chars[0] = sextet_char(b0[7:2]);
					job.chars[1] = sextet_char({b0[1:0], 4'b0000});
					job.chars[2] = PAD_CHAR;
					job.chars[3] = PAD_CHAR;
					job.last_idx = JOB_IDX_W'(3);
					job_push     = accept;
				end
				2'd2: begin
					job.chars[0] = sextet_char(b0[7:2]);
					job.chars[1] = sextet_char({b0[1:0], b1[7:4]});
					job.chars[2] = sextet_char({b1[3:0], 2'b00});
					job.chars[3] = PAD_CHAR;
					job.last_idx = JOB_IDX_W'(3);
					job_push     = accept;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			phase_q  <= '0;
			groups_q <= '0;
		end else if (accept) begin
			if (mode == MODE_CLOSE) begin
				held_q   <= '0;
				phase_q  <= '0;
				groups_q <= '0;
			end else begin
				case (phase_q)
					2'd0: begin
						held_q  <= {8'h00, data_byte};
						phase_q <= 2'd1;
						if (line_full) begin
							groups_q <= '0;
						end
					end
					2'd1: begin
						held_q  <= {held_q[7:0], data_byte};
						phase_q <= 2'd2;
					end
					default: begin
						held_q   <= '0;
						phase_q  <= '0;
						groups_q <= groups_q + GROUP_W'(1);
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/b64lwe_jobq.sv =====
// Short job queue between the front and back ends.
`default_nettype none

module b64lwe_jobq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr,
	input  wire b64lwe_pkg::job_t  wr_job,
	input  wire logic              rd,
	output b64lwe_pkg::job_t       rd_job,
	output b64lwe_pkg::jobq_stat_t stat
);
	import b64lwe_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.avail = (count_q != '0);
	assign rd_job     = mem_q[rd_ptr_q];
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && stat.avail;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/b64lwe_back.sv =====
// Back end: takes jobs from the queue and hands out one character per beat.
`default_nettype none

module b64lwe_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire b64lwe_pkg::job_t       job,
	input  wire b64lwe_pkg::jobq_stat_t stat,
	output logic                        job_take,
	input  wire logic                   pop,
	output logic [7:0]                  out_char,
	output logic                        last_of_run,
	output logic                        empty
);
	import b64lwe_pkg::*;

	job_t                 cur_q;
	logic [JOB_IDX_W-1:0] idx_q;
	logic                 busy_q;
	logic [CHAR_W-1:0]    char_q;
	logic                 last_q;
	logic                 valid_q;

	logic out_ready;
	logic cur_last;
	logic cur_done;

	assign out_ready = !valid_q || pop;
	assign cur_last  = (idx_q == cur_q.last_idx);
	assign cur_done  = busy_q && out_ready && cur_last;
	assign job_take  = stat.avail && (!busy_q || cur_done);

	assign out_char    = char_q;
	assign last_of_run = last_q;
	assign empty       = !valid_q;

	always_ff @(posedge clk) begin
		if (busy_q && out_ready) begin
			char_q <= cur_q.chars[idx_q];
			last_q <= cur_last;
		end
		if (job_take) begin
			cur_q <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			busy_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (busy_q && out_ready) begin
				valid_q <= 1'b1;
				idx_q   <= idx_q + JOB_IDX_W'(1);
			end else if (pop) begin
				valid_q <= 1'b0;
			end
			if (job_take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (cur_done) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/base64_line_wrapping_encoder_unit.sv =====
// Top level of the base64 line-wrapping encoder: configuration registers and the three parts.
// A group's first character passes the job queue, the back end's job register and the output register.
// Throughput: one byte per cycle while the job queue has room; one character per cycle out while popped.
// A group gives four characters for three bytes, so a steady byte stream is paced by the character output.
// Reset (arst_n low, asynchronous): queue and output empty, no bytes held, line count
// zero, wrapping off and 20 groups per line.
`default_nettype none

module base64_line_wrapping_encoder_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// input side
	input  wire logic                                 push,
	output logic                                      full,
	input  wire logic                                 mode,
	input  wire logic [7:0]                           data_byte,
	// result side
	output logic                                      empty,
	input  wire logic                                 pop,
	output logic [7:0]                                out_char,
	output logic                                      last_of_run,
	// configuration
	input  wire logic                                 cfg_we,
	input  wire logic [b64lwe_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [b64lwe_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import b64lwe_pkg::*;

	logic               wrap_enable_q;
	logic [GROUP_W-1:0] line_groups_q;

	logic       accept;
	job_t       front_job;
	logic       front_push;
	job_t       head_job;
	jobq_stat_t q_stat;
	logic       job_take;

	// Configuration writes land straight in the registers; indexes past the list drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_enable_q <= 1'b0;
			line_groups_q <= LINE_GROUPS_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_WRAP_ENABLE: wrap_enable_q <= cfg_wdata[0];
				CFG_LINE_GROUPS: line_groups_q <= cfg_wdata[GROUP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Hold off the input side whenever the job queue is full, even for bytes that would
	// produce nothing: this keeps the accept path free of the classification logic.
	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;

	// Front end: group assembly, line counting and character lookup.
	b64lwe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.mode        (mode),
		.data_byte   (data_byte),
		.wrap_enable (wrap_enable_q),
		.line_groups (line_groups_q),
		.job         (front_job),
		.job_push    (front_push)
	);

	// Job queue: lets the byte stream run on while characters drain at one per beat.
	b64lwe_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (front_push),
		.wr_job (front_job),
		.rd     (job_take),
		.rd_job (head_job),
		.stat   (q_stat)
	);

	// Back end: serialise each job into the output register, last beat flagged.
	b64lwe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (head_job),
		.stat        (q_stat),
		.job_take    (job_take),
		.pop         (pop),
		.out_char    (out_char),
		.last_of_run (last_of_run),
		.empty       (empty)
	);

endmodule

`default_nettype wire

// ===== hdl/b64lwe_checker.sv =====
// Port-level checker for the base64 line-wrapping encoder, bound to the top level.
`default_nettype none

module b64lwe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [7:0] out_char,
	input wire logic       last_of_run
);
	import b64lwe_pkg::*;

	logic legal_char;

	assign legal_char = (out_char >= 8'h41 && out_char <= 8'h5A) ||
	                    (out_char >= 8'h61 && out_char <= 8'h7A) ||
	                    (out_char >= 8'h30 && out_char <= 8'h39) ||
	                    (out_char == 8'h2B) || (out_char == 8'h2F) ||
	                    (out_char == PAD_CHAR) || (out_char == NEWLINE_CHAR);

	// A waiting beat holds until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_char) && $stable(last_of_run)))
		else $error("result beat changed while stalled");

	a_alphabet: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> legal_char)
		else $error("character outside the base64 set");

	// A newline is always a run on its own.
	a_newline_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_char == NEWLINE_CHAR) |-> last_of_run)
		else $error("newline not flagged as last of run");

	// Padding only ever runs to the end of a group.
	a_pad_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && out_char == PAD_CHAR && !last_of_run) |=>
		(!empty && out_char == PAD_CHAR))
		else $error("padding followed by a non-padding beat");

endmodule

bind base64_line_wrapping_encoder_unit b64lwe_checker u_b64lwe_checker (.*);

`default_nettype wire

// ===== bench/base64_line_wrapping_encoder_unit_test.sv =====
// Self-checking bench for the base64 line-wrapping encoder: directed and random byte streams.
`timescale 1ns / 100ps

// One expected output character and its end-of-run flag.
typedef struct {
	logic [7:0] ch;
	logic       last;
} b64_char_beat_t;

class b64_char_tracker;
	string          alphabet;
	logic           wrap_on;
	logic [7:0]     groups_per_line;
	logic [15:0]    held;
	logic [1:0]     held_count;
	logic [7:0]     line_count;
	b64_char_beat_t pending_chars[$];
	int             mismatches;
	int             items_noted;
	int             chars_checked;
	int             newlines_seen;
	int             pads_seen;

	function new();
		alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
		wrap_on = 1'b0;
		groups_per_line = b64lwe_pkg::LINE_GROUPS_RESET;
		held = '0;
		held_count = '0;
		line_count = '0;
		mismatches = 0;
		items_noted = 0;
		chars_checked = 0;
		newlines_seen = 0;
		pads_seen = 0;
	endfunction

	function logic [7:0] to_ascii(input logic [5:0] v);
		return alphabet[int'(v)];
	endfunction

	function void set_reg(input logic [b64lwe_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
		if (idx == b64lwe_pkg::CFG_WRAP_ENABLE)
			wrap_on = val[0];
		else if (idx == b64lwe_pkg::CFG_LINE_GROUPS)
			groups_per_line = val;
	endfunction

	// Work out the characters an accepted input beat causes and queue them.
	function void note_item(input logic m, input logic [7:0] b);
		logic [7:0]     run[$];
		logic [7:0]     limit;
		logic [7:0]     b0;
		logic [7:0]     b1;
		b64_char_beat_t beat;
		limit = (groups_per_line == 8'd0) ? 8'd1 : groups_per_line;
		b0 = held[15:8];
		b1 = held[7:0];
		items_noted++;
		if (m == b64lwe_pkg::MODE_DATA) begin
			case (held_count)
				2'd0: begin
					if (line_count >= limit) begin
						line_count = '0;
						if (wrap_on)
							run.push_back(b64lwe_pkg::NEWLINE_CHAR);
					end
					held = {8'h00, b};
					held_count = 2'd1;
				end
				2'd1: begin
					held = {held[7:0], b};
					held_count = 2'd2;
				end
				default: begin
					run.push_back(to_ascii(b0[7:2]));
					run.push_back(to_ascii({b0[1:0], b1[7:4]}));
					run.push_back(to_ascii({b1[3:0], b[7:6]}));
					run.push_back(to_ascii(b[5:0]));
					held = '0;
					held_count = 2'd0;
					line_count = line_count + 8'd1;
				end
			endcase
		end else begin
			if (held_count == 2'd1) begin
				run.push_back(to_ascii(b1[7:2]));
				run.push_back(to_ascii({b1[1:0], 4'h0}));
				run.push_back(b64lwe_pkg::PAD_CHAR);
				run.push_back(b64lwe_pkg::PAD_CHAR);
			end else if (held_count == 2'd2) begin
				run.push_back(to_ascii(b0[7:2]));
				run.push_back(to_ascii({b0[1:0], b1[7:4]}));
				run.push_back(to_ascii({b1[3:0], 2'b00}));
				run.push_back(b64lwe_pkg::PAD_CHAR);
			end
			held = '0;
			held_count = 2'd0;
			line_count = '0;
		end
		foreach (run[i]) begin
			beat.ch = run[i];
			beat.last = (i == run.size() - 1);
			pending_chars.push_back(beat);
		end
	endfunction

	// Compare a popped character with the oldest expectation.
	function void check_char(input logic [7:0] got_ch, input logic got_last);
		b64_char_beat_t want;
		chars_checked++;
		if (got_ch == b64lwe_pkg::NEWLINE_CHAR)
			newlines_seen++;
		if (got_ch == b64lwe_pkg::PAD_CHAR)
			pads_seen++;
		if (pending_chars.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] unexpected character %02h last %0b", $realtime, got_ch, got_last);
			return;
		end
		want = pending_chars.pop_front();
		if (got_ch !== want.ch || got_last !== want.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] mismatch: expected char %02h last %0b, got char %02h last %0b",
					$realtime, want.ch, want.last, got_ch, got_last);
		end
	endfunction
endclass

module base64_line_wrapping_encoder_unit_test;
	import b64lwe_pkg::*;

	localparam int LONG_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES    = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  mode;
	logic [7:0]            data_byte;
	logic                  pop;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	wire                   full;
	wire                   empty;
	wire [7:0]             out_char;
	wire                   last_of_run;

	b64_char_tracker tracker = new();

	// Sender pacing and the handshake with the result side for long hold-offs.
	int burst_left    = 0;
	bit gaps_on       = 1'b1;
	int hold_requests = 0;

	base64_line_wrapping_encoder_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.data_byte   (data_byte),
		.empty       (empty),
		.pop         (pop),
		.out_char    (out_char),
		.last_of_run (last_of_run),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offer one beat and hold it until the block takes it. Between bursts drop push
	// for a few cycles so that gaps land on every phase of the group.
	task automatic send_item(input logic m, input logic [7:0] b);
		if (burst_left == 0) begin
			if (gaps_on) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		push <= 1'b1;
		mode <= m;
		data_byte <= b;
		do @(posedge clk); while (full);
		tracker.note_item(m, b);
		burst_left--;
	endtask

	// Stop sending, wait for every expected character, let held work settle,
	// then write both registers back to back.
	task automatic apply_setting(input logic wrap, input logic [7:0] groups);
		push <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (tracker.pending_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_WRAP_ENABLE;
		cfg_wdata <= {7'($urandom_range(0, 127)), wrap};
		@(posedge clk);
		tracker.set_reg(CFG_WRAP_ENABLE, {7'd0, wrap});
		cfg_idx <= CFG_LINE_GROUPS;
		cfg_wdata <= groups;
		@(posedge clk);
		tracker.set_reg(CFG_LINE_GROUPS, groups);
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed runs (some bytes then a close), with long runs to cross line
	// boundaries and a sprinkling of lone beats of either kind as noise.
	task automatic random_phase(input int n_items);
		int target;
		int run_len;
		target = tracker.items_noted + n_items;
		while (tracker.items_noted < target) begin
			if ($urandom_range(0, 9) < 8) begin
				run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 9);
				repeat (run_len) send_item(MODE_DATA, 8'($urandom_range(0, 255)));
				send_item(MODE_CLOSE, 8'($urandom_range(0, 255)));
			end else begin
				send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Result side: check every popped beat, stall on a random sixteen-bit pattern that is redrawn once
	// all its bits are used, and honour long hold-off requests by counting cycles here.
	initial begin : result_side
		int          hold_left;
		int          holds_served;
		int          pattern_age;
		logic [15:0] pop_pattern;
		hold_left = 0;
		holds_served = 0;
		pattern_age = 0;
		pop_pattern = '1;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				tracker.check_char(out_char, last_of_run);
			if (holds_served != hold_requests) begin
				hold_left = LONG_HOLD_CYCLES;
				holds_served = hold_requests;
			end
			if (pattern_age == 0) begin
				case ($urandom_range(0, 3))
					0: pop_pattern = '1;
					1: pop_pattern = 16'($urandom);
					2: pop_pattern = 16'($urandom) & 16'($urandom);
					default: pop_pattern = 16'($urandom) | 16'($urandom);
				endcase
				pattern_age = 16;
			end
			pattern_age--;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= pop_pattern[pattern_age];
			end
		end
	end

	// Stimulus and verdict.
	initial begin : stimulus
		int spin;
		arst_n = 1'b0;
		push <= 1'b0;
		mode <= MODE_DATA;
		data_byte <= 8'h00;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_WRAP_ENABLE;
		cfg_wdata <= '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Reset setting: no wrapping. All-zero and all-one groups, an empty close,
		// then a lone byte flushed with double padding.
		send_item(MODE_DATA, 8'h00);
		send_item(MODE_DATA, 8'h00);
		send_item(MODE_DATA, 8'h00);
		send_item(MODE_DATA, 8'hFF);
		send_item(MODE_DATA, 8'hFF);
		send_item(MODE_DATA, 8'hFF);
		send_item(MODE_CLOSE, 8'h00);
		send_item(MODE_DATA, 8'h4D);
		send_item(MODE_CLOSE, 8'hFF);

		// One group per line: the second group starts with a newline, a two-byte close
		// gets single padding, a close with nothing held ignores its byte, and a close
		// restarts the line so the next group has no newline.
		apply_setting(1'b1, 8'd1);
		send_item(MODE_DATA, 8'h4D);
		send_item(MODE_DATA, 8'h61);
		send_item(MODE_DATA, 8'h6E);
		send_item(MODE_DATA, 8'h4D);
		send_item(MODE_DATA, 8'h61);
		send_item(MODE_DATA, 8'h6E);
		send_item(MODE_DATA, 8'h4D);
		send_item(MODE_DATA, 8'h61);
		send_item(MODE_CLOSE, 8'h00);
		send_item(MODE_CLOSE, 8'hA5);
		send_item(MODE_DATA, 8'h00);
		send_item(MODE_CLOSE, 8'h5A);

		// Zero groups per line behaves as one.
		apply_setting(1'b1, 8'd0);
		send_item(MODE_DATA, 8'h00);
		send_item(MODE_DATA, 8'h00);
		send_item(MODE_DATA, 8'h00);
		send_item(MODE_DATA, 8'hFF);
		send_item(MODE_DATA, 8'hFF);
		send_item(MODE_DATA, 8'hFF);

		// Random part across several settings.
		apply_setting(1'b1, 8'd2);
		random_phase(70);

		// Back-pressure: hold the result side off while the sender keeps offering.
		apply_setting(1'b1, 8'd3);
		gaps_on = 1'b0;
		hold_requests++;
		random_phase(70);
		gaps_on = 1'b1;

		apply_setting(1'b0, 8'd1);
		random_phase(50);
		apply_setting(1'b1, 8'd255);
		random_phase(50);
		apply_setting(1'b1, 8'd0);
		random_phase(50);
		apply_setting(1'b1, 8'($urandom_range(1, 6)));
		random_phase(60);

		// Drain, then give the block time to show anything it should not.
		push <= 1'b0;
		spin = 0;
		while (tracker.pending_chars.size() != 0 && spin < 10000) begin
			@(posedge clk);
			spin++;
		end
		repeat (20) @(posedge clk);

		$display("Covered %0d input beats and %0d output characters (%0d newlines, %0d pads).",
			tracker.items_noted, tracker.chars_checked, tracker.newlines_seen, tracker.pads_seen);
		$display("Settings swept: wrapping on and off; line groups 0, 1, 2, 3, 255 and random.");
		if (tracker.mismatches > 10)
			$display("%0d mismatches in total", tracker.mismatches);
		if (tracker.pending_chars.size() != 0)
			$display("%0d expected characters never arrived", tracker.pending_chars.size());
		if (tracker.mismatches == 0 && tracker.pending_chars.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin : watchdog
		#2000000;
		$display("Timed out waiting on the block");
		$display("Regression FAIL");
		$finish;
	end

endmodule
